@@ hw/rtl/rvmie_pkg.sv @@
// shared types, constants and codes for the register machine execute block
`default_nettype none
package rvmie_pkg;
   localparam int REG_COUNT_DEFAULT   = 16;
   localparam int STACK_DEPTH_DEFAULT = 256;
   localparam logic [31:0] BAD_OPERAND = 32'h4000_0000;
   localparam logic [31:0] HEAP_BIT    = 32'h8000_0000;

   localparam logic [3:0] KIND_NONE     = 4'h0;
   localparam logic [3:0] KIND_LITERAL  = 4'h1;
   localparam logic [3:0] KIND_REGISTER = 4'h2;
   localparam logic [3:0] KIND_ADDRESS  = 4'h3;

   localparam logic [2:0] ST_RUN       = 3'd0;
   localparam logic [2:0] ST_HALT      = 3'd1;
   localparam logic [2:0] ST_OPERAND   = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_UNDERFLOW = 3'd4;
   localparam logic [2:0] ST_DIVZERO   = 3'd5;

   localparam logic [4:0] ACT_NOOP = 5'd0;
   localparam logic [4:0] ACT_PUSH = 5'd1;
   localparam logic [4:0] ACT_POP  = 5'd2;
   localparam logic [4:0] ACT_SET  = 5'd3;
   localparam logic [4:0] ACT_SWAP = 5'd4;
   localparam logic [4:0] ACT_ADD  = 5'd5;
   localparam logic [4:0] ACT_SUB  = 5'd6;
   localparam logic [4:0] ACT_MULT = 5'd7;
   localparam logic [4:0] ACT_DIV  = 5'd8;
   localparam logic [4:0] ACT_MOD  = 5'd9;
   localparam logic [4:0] ACT_CALL = 5'd10;
   localparam logic [4:0] ACT_RET  = 5'd11;
   localparam logic [4:0] ACT_CMP  = 5'd12;
   localparam logic [4:0] ACT_JMP  = 5'd13;
   localparam logic [4:0] ACT_JZ   = 5'd14;
   localparam logic [4:0] ACT_JNZ  = 5'd15;
   localparam logic [4:0] ACT_JE   = 5'd16;
   localparam logic [4:0] ACT_JNE  = 5'd17;
   localparam logic [4:0] ACT_JGT  = 5'd18;
   localparam logic [4:0] ACT_JGTE = 5'd19;
   localparam logic [4:0] ACT_JLT  = 5'd20;
   localparam logic [4:0] ACT_JLTE = 5'd21;
   localparam logic [4:0] ACT_HALT = 5'd22;

   // datapath operation chosen by the controller
   typedef enum logic [3:0] {
      OP_IDLE, OP_DECODE, OP_EXEC, OP_MUL, OP_DIV_START, OP_DIV_STEP,
      OP_CALL_PUSH, OP_CALL_FINISH, OP_RET_POP, OP_RET_WAIT, OP_RET_FINISH,
      OP_POP_WAIT, OP_POP_FINISH
   } dp_op_type;

   // command from controller to datapath
   typedef struct packed {
      dp_op_type op;
      logic      load;
   } dp_cmd_type;

   // decode outcome reported back by the datapath
   typedef enum logic [2:0] {
      SEQ_SIMPLE, SEQ_MUL, SEQ_DIV, SEQ_CALL, SEQ_RET, SEQ_POP
   } seq_kind_type;

   typedef struct packed {
      seq_kind_type kind;
      logic         div_done;
      logic         call_last;
      logic         ret_last;
   } dp_status_type;
endpackage
`default_nettype wire

@@ hw/rtl/rvmie_ram.sv @@
// generic single port write, single port registered read memory
`default_nettype none
module rvmie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hw/rtl/rvmie_ctrl.sv @@
// controller state machine sequencing one instruction at a time
`default_nettype none
module rvmie_ctrl
   import rvmie_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_fire,
   input  wire logic          rsp_free,
   input  wire dp_status_type stat,
   output logic               req_ready,
   output logic               rsp_load,
   output dp_cmd_type         cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_EXEC, S_MUL, S_DIV_STEP, S_CALL, S_CALL_FIN,
      S_RET, S_RET_WAIT, S_RET_FIN, S_POP_WAIT, S_POP_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_fire) state_in = S_DECODE;
         S_DECODE: begin
            case (stat.kind)
               SEQ_MUL:  state_in = S_MUL;
               SEQ_DIV:  state_in = S_DIV_STEP;
               SEQ_CALL: state_in = S_CALL;
               SEQ_RET:  state_in = S_RET;
               SEQ_POP:  state_in = S_POP_WAIT;
               default:  state_in = S_EXEC;
            endcase
         end
         S_DIV_STEP: if (stat.div_done) state_in = S_EXEC;
         S_MUL:      state_in = S_EXEC;
         S_CALL:     if (stat.call_last) state_in = S_CALL_FIN;
         S_CALL_FIN: state_in = S_OUT;
         S_RET:      if (stat.ret_last) state_in = S_RET_WAIT;
         S_RET_WAIT: state_in = S_RET_FIN;
         S_RET_FIN:  state_in = S_OUT;
         S_POP_WAIT: state_in = S_POP_FIN;
         S_POP_FIN:  state_in = S_OUT;
         S_EXEC:     state_in = S_OUT;
         S_OUT:      if (rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd.load = req_fire;
      case (state_ff)
         S_DECODE:   cmd.op = (stat.kind == SEQ_DIV) ? OP_DIV_START : OP_DECODE;
         S_DIV_STEP: cmd.op = OP_DIV_STEP;
         S_MUL:      cmd.op = OP_MUL;
         S_EXEC:     cmd.op = OP_EXEC;
         S_CALL:     cmd.op = OP_CALL_PUSH;
         S_CALL_FIN: cmd.op = OP_CALL_FINISH;
         S_RET:      cmd.op = OP_RET_POP;
         S_RET_WAIT: cmd.op = OP_RET_WAIT;
         S_RET_FIN:  cmd.op = OP_RET_FINISH;
         S_POP_WAIT: cmd.op = OP_POP_WAIT;
         S_POP_FIN:  cmd.op = OP_POP_FINISH;
         default:    cmd.op = OP_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_OUT) && rsp_free;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/rvmie_dp.sv @@
// datapath: registers, accumulator, pc, stacks, alu and divider
`default_nettype none
module rvmie_dp
   import rvmie_pkg::*;
#(
   parameter int REG_COUNT   = REG_COUNT_DEFAULT,
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_cmd_type    cmd,
   input  wire logic [30:0]   code_size,
   input  wire logic [4:0]    action,
   input  wire logic [3:0]    first_kind,
   input  wire logic [3:0]    second_kind,
   input  wire logic [31:0]   first_operand,
   input  wire logic [31:0]   second_operand,
   output dp_status_type      stat,
   output logic [31:0]        pc_out,
   output logic [2:0]         status_out,
   output logic [31:0]        acc_out
);
   localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int PW = AW + 1;
   localparam logic [PW-1:0] LIMIT = PW'(STACK_DEPTH - 2);
   localparam logic [PW-1:0] RCNT  = PW'(REG_COUNT);
   localparam logic [RW-1:0] RLAST = RW'(REG_COUNT - 1);

   // instruction hold registers
   logic [4:0]  act_ff;
   logic [3:0]  k1_ff, k2_ff;
   logic [31:0] o1_ff, o2_ff;

   // architectural state
   logic [31:0]   regs_ff [REG_COUNT];
   logic [31:0]   acc_ff, pc_ff;
   logic [PW-1:0] dsp_ff, rsp_ff;
   logic [2:0]    st_ff;

   // decode results held between cycles
   logic [31:0] v1_ff, v2_ff, dst_ff, fall_ff;
   logic [RW-1:0] d_idx_ff, s_idx_ff;
   logic [2:0]  dec_st_ff;

   // multi-cycle unit registers
   logic [31:0] mul_ff;
   logic [31:0] quo_ff, rem_ff;
   logic [5:0]  div_cnt_ff;
   logic [RW-1:0] seq_ff;

   // combinational decode
   logic one, two, none, reg1, reg2;
   logic [31:0] val1, val2, fall, r1, r2;
   logic [RW-1:0] i1, i2;
   logic [2:0] dst;
   seq_kind_type kind;

   function automatic logic [31:0] opval(input logic [3:0] k, input logic [31:0] w,
                                         input logic [31:0] rv, input logic [30:0] cs);
      logic [31:0] res;
      res = BAD_OPERAND;
      case (k)
         KIND_LITERAL:  res = w;
         KIND_ADDRESS:  res = ((w & HEAP_BIT) != 0 || w < {1'b0, cs}) ? w : BAD_OPERAND;
         KIND_REGISTER: res = (w < 32'(REG_COUNT)) ? rv : BAD_OPERAND;
         default:       res = BAD_OPERAND;
      endcase
      return res;
   endfunction

   assign i1   = o1_ff[RW-1:0];
   assign i2   = o2_ff[RW-1:0];
   assign r1   = regs_ff[i1];
   assign r2   = regs_ff[i2];
   assign reg1 = (k1_ff == KIND_REGISTER) && (o1_ff < 32'(REG_COUNT));
   assign reg2 = (k2_ff == KIND_REGISTER) && (o2_ff < 32'(REG_COUNT));
   assign one  = (k1_ff != KIND_NONE) && (k2_ff == KIND_NONE);
   assign two  = (k1_ff != KIND_NONE) && (k2_ff != KIND_NONE);
   assign none = (k1_ff == KIND_NONE) && (k2_ff == KIND_NONE);
   assign val1 = opval(k1_ff, o1_ff, r1, code_size);
   assign val2 = opval(k2_ff, o2_ff, r2, code_size);
   assign fall = pc_ff + 32'd2 + ((k1_ff != KIND_NONE) ? 32'd4 : 32'd0)
                 + ((k2_ff != KIND_NONE) ? 32'd4 : 32'd0);

   // status and sequence kind of the held instruction
   always_comb begin
      dst  = ST_RUN;
      kind = SEQ_SIMPLE;
      if (k2_ff != KIND_NONE && k1_ff == KIND_NONE) begin
         dst = ST_OPERAND;
      end else begin
         case (act_ff)
            ACT_NOOP: dst = ST_RUN;
            ACT_PUSH: begin
               if (!one || !reg1) dst = ST_OPERAND;
               else if (dsp_ff >= LIMIT) dst = ST_OVERFLOW;
            end
            ACT_POP: begin
               if (!one || !reg1) dst = ST_OPERAND;
               else if (dsp_ff == '0) dst = ST_UNDERFLOW;
               else kind = SEQ_POP;
            end
            ACT_SET, ACT_ADD, ACT_SUB: begin
               if (!two || !reg1) dst = ST_OPERAND;
            end
            ACT_MULT: begin
               if (!two || !reg1) dst = ST_OPERAND;
               else kind = SEQ_MUL;
            end
            ACT_DIV, ACT_MOD: begin
               if (!two || !reg1) dst = ST_OPERAND;
               else if (val2 == '0) dst = ST_DIVZERO;
               else kind = SEQ_DIV;
            end
            ACT_SWAP: begin
               if (!two || !reg1 || !reg2 || o1_ff == o2_ff) dst = ST_OPERAND;
            end
            ACT_CALL: begin
               if (!one || k1_ff != KIND_ADDRESS) dst = ST_OPERAND;
               else if (dsp_ff + RCNT > LIMIT || rsp_ff >= LIMIT) dst = ST_OVERFLOW;
               else kind = SEQ_CALL;
            end
            ACT_RET: begin
               if (k1_ff != KIND_NONE ? !one : !none) dst = ST_OPERAND;
               else if (rsp_ff == '0) dst = ST_HALT;
               else if (dsp_ff < RCNT) dst = ST_UNDERFLOW;
               else kind = SEQ_RET;
            end
            ACT_CMP: if (!two) dst = ST_OPERAND;
            ACT_JMP, ACT_JZ, ACT_JNZ: if (!one) dst = ST_OPERAND;
            ACT_JE, ACT_JNE, ACT_JGT, ACT_JGTE, ACT_JLT, ACT_JLTE:
               if (!two) dst = ST_OPERAND;
            ACT_HALT: dst = none ? ST_HALT : ST_OPERAND;
            default:  dst = ST_OPERAND;
         endcase
      end
   end

   // stack memories
   logic          ds_we, rs_we;
   logic [AW-1:0] ds_wa, ds_ra, rs_wa, rs_ra;
   logic [31:0]   ds_wd, ds_rd, rs_rd;

   rvmie_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_dstack (
      .clock(clock), .wr_en(ds_we), .wr_addr(ds_wa), .wr_data(ds_wd),
      .rd_addr(ds_ra), .rd_data(ds_rd));
   rvmie_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_rstack (
      .clock(clock), .wr_en(rs_we), .wr_addr(rs_wa), .wr_data(fall_ff),
      .rd_addr(rs_ra), .rd_data(rs_rd));

   // stack port control
   always_comb begin
      ds_we = 1'b0;
      ds_wa = dsp_ff[AW-1:0];
      ds_wd = regs_ff[seq_ff];
      ds_ra = dsp_ff[AW-1:0] - AW'(1);
      rs_we = 1'b0;
      rs_wa = rsp_ff[AW-1:0];
      rs_ra = rsp_ff[AW-1:0] - AW'(1);
      case (cmd.op)
         OP_EXEC: begin
            if (act_ff == ACT_PUSH && dec_st_ff == ST_RUN) begin
               ds_we = 1'b1;
               ds_wd = regs_ff[d_idx_ff];
            end
         end
         OP_CALL_PUSH:   ds_we = 1'b1;
         OP_CALL_FINISH: rs_we = 1'b1;
         default: ;
      endcase
   end

   // divider: restoring, one quotient bit a cycle
   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, v2_ff};

   // pc after a simple instruction: fall-through or jump target
   logic [31:0] exec_pc;
   always_comb begin
      exec_pc = fall_ff;
      case (act_ff)
         ACT_JMP:  exec_pc = o1_ff;
         ACT_JZ:   if (acc_ff == '0) exec_pc = v1_ff;
         ACT_JNZ:  if (acc_ff != '0) exec_pc = v1_ff;
         ACT_JE:   if (acc_ff == v1_ff) exec_pc = v2_ff;
         ACT_JNE:  if (acc_ff != v1_ff) exec_pc = v2_ff;
         ACT_JGT:  if (acc_ff >  v1_ff) exec_pc = v2_ff;
         ACT_JGTE: if (acc_ff >= v1_ff) exec_pc = v2_ff;
         ACT_JLT:  if (acc_ff <  v1_ff) exec_pc = v2_ff;
         ACT_JLTE: if (acc_ff <= v1_ff) exec_pc = v2_ff;
         default: ;
      endcase
   end

   assign stat.kind      = kind;
   // last of the 32 steps is in progress
   assign stat.div_done  = (div_cnt_ff == 6'd31);
   assign stat.call_last = (seq_ff == RLAST);
   assign stat.ret_last  = (seq_ff == '0);

   assign pc_out     = pc_ff;
   assign status_out = st_ff;
   assign acc_out    = acc_ff;

   // sequential datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REG_COUNT; r++) regs_ff[r] <= '0;
         acc_ff <= '0;
         pc_ff  <= '0;
         dsp_ff <= '0;
         rsp_ff <= '0;
         st_ff  <= ST_RUN;
      end else begin
         case (cmd.op)
            OP_DECODE, OP_DIV_START: begin
               v1_ff     <= val1;
               v2_ff     <= val2;
               dst_ff    <= r1;
               d_idx_ff  <= i1;
               s_idx_ff  <= i2;
               fall_ff   <= fall;
               dec_st_ff <= dst;
               seq_ff    <= (act_ff == ACT_RET) ? RLAST : '0;
               quo_ff    <= r1;
               rem_ff    <= '0;
               div_cnt_ff <= '0;
            end
            OP_MUL: mul_ff <= dst_ff * v2_ff;
            OP_DIV_STEP: begin
               if (!trial[32]) begin
                  rem_ff <= trial[31:0];
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[30:0], quo_ff[31]};
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               div_cnt_ff <= div_cnt_ff + 6'd1;
            end
            OP_EXEC: begin
               st_ff <= dec_st_ff;
               if (dec_st_ff == ST_RUN || dec_st_ff == ST_HALT) begin
                  pc_ff <= exec_pc;
                  case (act_ff)
                     ACT_PUSH: dsp_ff <= dsp_ff + PW'(1);
                     ACT_SET:  regs_ff[d_idx_ff] <= v2_ff;
                     ACT_ADD:  regs_ff[d_idx_ff] <= dst_ff + v2_ff;
                     ACT_SUB:  regs_ff[d_idx_ff] <= dst_ff - v2_ff;
                     ACT_MULT: regs_ff[d_idx_ff] <= mul_ff;
                     ACT_DIV:  regs_ff[d_idx_ff] <= quo_ff;
                     ACT_MOD:  regs_ff[d_idx_ff] <= rem_ff;
                     ACT_SWAP: begin
                        regs_ff[d_idx_ff] <= regs_ff[s_idx_ff];
                        regs_ff[s_idx_ff] <= dst_ff;
                     end
                     ACT_RET:  acc_ff <= (k1_ff != KIND_NONE) ? v1_ff : acc_ff;
                     ACT_CMP:  acc_ff <= v1_ff - v2_ff;
                     default: ;
                  endcase
               end
            end
            OP_CALL_PUSH: begin
               dsp_ff <= dsp_ff + PW'(1);
               seq_ff <= seq_ff + RW'(1);
            end
            OP_CALL_FINISH: begin
               rsp_ff <= rsp_ff + PW'(1);
               pc_ff  <= o1_ff;
               st_ff  <= ST_RUN;
            end
            OP_RET_POP: begin
               // read issued this cycle, lands next cycle at seq_ff
               dsp_ff <= dsp_ff - PW'(1);
               if (seq_ff != '0) seq_ff <= seq_ff - RW'(1);
               if (seq_ff != RLAST) regs_ff[seq_ff + RW'(1)] <= ds_rd;
            end
            OP_RET_WAIT: begin
               regs_ff[seq_ff] <= ds_rd;
               rsp_ff <= rsp_ff - PW'(1);
            end
            OP_RET_FINISH: begin
               pc_ff  <= rs_rd;
               acc_ff <= (k1_ff != KIND_NONE) ? v1_ff : acc_ff;
               st_ff  <= ST_RUN;
            end
            OP_POP_WAIT: dsp_ff <= dsp_ff - PW'(1);
            OP_POP_FINISH: begin
               regs_ff[d_idx_ff] <= ds_rd;
               pc_ff <= fall_ff;
               st_ff <= ST_RUN;
            end
            default: ;
         endcase
      end
      if (cmd.load) begin
         act_ff <= action;
         k1_ff  <= first_kind;
         k2_ff  <= second_kind;
         o1_ff  <= first_operand;
         o2_ff  <= second_operand;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/register_vm_instruction_execute.sv @@
// top level of the register machine instruction execute block
// decode and result states frame each instruction: mult adds a multiply step before
// execute, div and mod a divider step per quotient bit, pop a wait and finish step,
// call a push per register, ret a pop per register; one in flight, the result register
// frees the next input while a result waits to be taken
// synchronous reset clears registers, accumulator, pc and stack pointers
`default_nettype none
module register_vm_instruction_execute
   import rvmie_pkg::*;
#(
   parameter int REGISTER_COUNT = REG_COUNT_DEFAULT,
   parameter int STACK_DEPTH    = STACK_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [30:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[4:0], first_kind[8:5], second_kind[12:9], first_operand[44:13],
   // second_operand[76:45], zero fill to 80
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // next_pc[31:0], status[34:32], acc_value[66:35], zero fill to 72
   output logic [71:0]      rsp_tdata
);
   logic [30:0]   code_size_ff;
   logic          rsp_valid_ff;
   logic [71:0]   rsp_data_ff;
   logic          req_fire, rsp_free, rsp_load;
   dp_cmd_type    cmd;
   dp_status_type stat;
   logic [31:0]   pc, acc;
   logic [2:0]    st;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   rvmie_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .rsp_free(rsp_free),
      .stat(stat), .req_ready(req_tready), .rsp_load(rsp_load), .cmd(cmd));

   rvmie_dp #(.REG_COUNT(REGISTER_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .code_size(code_size_ff),
      .action(req_tdata[4:0]), .first_kind(req_tdata[8:5]),
      .second_kind(req_tdata[12:9]), .first_operand(req_tdata[44:13]),
      .second_operand(req_tdata[76:45]), .stat(stat),
      .pc_out(pc), .status_out(st), .acc_out(acc));

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         code_size_ff <= '0;
      end else if (csr_we) begin
         code_size_ff <= csr_wdata;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= {5'd0, acc, st, pc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // no new transfer accepted while an instruction is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input ready right after transfer");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[34:32] <= ST_DIVZERO)
      else $error("status code out of range");
   a_load: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !rsp_load)
      else $error("result loaded right after transfer");
endmodule
`default_nettype wire
